// File: rtl/rv64ieu_pkg.sv
// Shared types and codes for the RV64 integer execute unit.
// Used by the top level, the execute datapath and the port checker.
package rv64ieu_pkg;

    // Default datapath width; the top level may be built for 32 to 64 bits.
    localparam int DEFAULT_XLEN = 64;

    // Operation codes of the decoded instruction.
    typedef enum logic [5:0] {
        CMD_LUI     = 6'd0,
        CMD_AUIPC   = 6'd1,
        CMD_JAL     = 6'd2,
        CMD_JALR    = 6'd3,
        CMD_BEQ     = 6'd4,
        CMD_BNE     = 6'd5,
        CMD_BLT     = 6'd6,
        CMD_BGE     = 6'd7,
        CMD_BLTU    = 6'd8,
        CMD_BGEU    = 6'd9,
        CMD_LB      = 6'd10,
        CMD_LH      = 6'd11,
        CMD_LW      = 6'd12,
        CMD_LBU     = 6'd13,
        CMD_LHU     = 6'd14,
        CMD_SB      = 6'd15,
        CMD_SH      = 6'd16,
        CMD_SW      = 6'd17,
        CMD_ADDI    = 6'd18,
        CMD_SLTI    = 6'd19,
        CMD_SLTIU   = 6'd20,
        CMD_XORI    = 6'd21,
        CMD_ORI     = 6'd22,
        CMD_ANDI    = 6'd23,
        CMD_SLLI    = 6'd24,
        CMD_SRLI    = 6'd25,
        CMD_SRAI    = 6'd26,
        CMD_ADD     = 6'd27,
        CMD_SUB     = 6'd28,
        CMD_SLL     = 6'd29,
        CMD_SLT     = 6'd30,
        CMD_SLTU    = 6'd31,
        CMD_XOR     = 6'd32,
        CMD_SRL     = 6'd33,
        CMD_SRA     = 6'd34,
        CMD_OR      = 6'd35,
        CMD_AND     = 6'd36,
        CMD_FENCE   = 6'd37,
        CMD_FENCE_I = 6'd38,
        CMD_ECALL   = 6'd39,
        CMD_EBREAK  = 6'd40
    } cmd_t;

    // Memory request codes.
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    // Access size codes.
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // Exception codes.
    localparam logic [1:0] EXC_NONE       = 2'd0;
    localparam logic [1:0] EXC_MISALIGNED = 2'd1;
    localparam logic [1:0] EXC_ECALL      = 2'd2;
    localparam logic [1:0] EXC_BREAK      = 2'd3;

    // One decoded instruction.
    typedef struct packed {
        logic [5:0]         command;
        logic [4:0]         dest_index;
        logic [63:0]        first_value;
        logic [63:0]        second_value;
        logic signed [31:0] immediate;
        logic [63:0]        current_pc;
        logic [63:0]        fall_through_pc;
    } item_t;

    // One execution result.
    typedef struct packed {
        logic        write_enable;
        logic [4:0]  write_index;
        logic [63:0] write_value;
        logic [63:0] new_pc;
        logic [1:0]  memory_request;
        logic [63:0] memory_address;
        logic [1:0]  access_size;
        logic        load_signed;
        logic [63:0] store_value;
        logic [1:0]  exception_code;
        logic        flush_fetch;
    } result_t;

endpackage

// File: rtl/rv64ieu_alu.sv
// Execute datapath: decodes the operation and forms the complete result.
// Purely combinational; depends on rv64ieu_pkg.
module rv64ieu_alu
    import rv64ieu_pkg::*;
#(
    parameter int XLEN = DEFAULT_XLEN
)
(
    input  item_t   item,
    input  logic    compressed_enabled,
    output result_t result
);

    localparam int SHW = $clog2(XLEN);

    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] imm;
    logic [XLEN-1:0] pc;
    logic [XLEN-1:0] fall;
    logic [XLEN-1:0] a_imm_sum;
    logic [XLEN-1:0] pc_imm_sum;
    logic [XLEN-1:0] a_b_sum;
    logic [XLEN-1:0] a_b_diff;
    logic [SHW-1:0]  samt_i;
    logic [SHW-1:0]  samt_r;
    logic            lt_ab;
    logic            ltu_ab;
    logic            lt_ai;
    logic            ltu_ai;

    logic            wr;
    logic [XLEN-1:0] val;
    logic [XLEN-1:0] npc;
    logic [1:0]      req;
    logic [XLEN-1:0] addr;
    logic [1:0]      size;
    logic            lsig;
    logic [XLEN-1:0] sval;
    logic [1:0]      exc;
    logic            flush;
    logic            jump;
    logic [XLEN-1:0] target;
    logic            misaligned;

    assign a    = item.first_value[XLEN-1:0];
    assign b    = item.second_value[XLEN-1:0];
    assign imm  = XLEN'(item.immediate);
    assign pc   = item.current_pc[XLEN-1:0];
    assign fall = item.fall_through_pc[XLEN-1:0];

    assign a_imm_sum  = a + imm;
    assign pc_imm_sum = pc + imm;
    assign a_b_sum    = a + b;
    assign a_b_diff   = a - b;

    assign samt_i = imm[SHW-1:0];
    assign samt_r = b[SHW-1:0];

    assign lt_ab  = $signed(a) < $signed(b);
    assign ltu_ab = a < b;
    assign lt_ai  = $signed(a) < $signed(imm);
    assign ltu_ai = a < imm;

    always_comb
    begin
        wr     = 1'b0;
        val    = '0;
        npc    = fall;
        req    = MEM_NONE;
        addr   = '0;
        size   = SIZE_BYTE;
        lsig   = 1'b0;
        sval   = '0;
        exc    = EXC_NONE;
        flush  = 1'b0;
        jump   = 1'b0;
        target = pc_imm_sum;

        unique case (item.command) inside
            CMD_LUI:     begin wr = 1'b1; val = imm;        end
            CMD_AUIPC:   begin wr = 1'b1; val = pc_imm_sum; end
            CMD_JAL:     begin jump = 1'b1; wr = 1'b1; val = fall; end
            CMD_JALR:
            begin
                jump   = 1'b1;
                target = {a_imm_sum[XLEN-1:1], 1'b0};
                wr     = 1'b1;
                val    = fall;
            end
            CMD_BEQ:     jump = (a == b);
            CMD_BNE:     jump = (a != b);
            CMD_BLT:     jump = lt_ab;
            CMD_BGE:     jump = !lt_ab;
            CMD_BLTU:    jump = ltu_ab;
            CMD_BGEU:    jump = !ltu_ab;
            CMD_LB, CMD_LH, CMD_LW, CMD_LBU, CMD_LHU:
            begin
                req  = MEM_LOAD;
                addr = a_imm_sum;
            end
            CMD_SB, CMD_SH, CMD_SW:
            begin
                req  = MEM_STORE;
                addr = a_imm_sum;
                sval = b;
            end
            CMD_ADDI:    begin wr = 1'b1; val = a_imm_sum;              end
            CMD_SLTI:    begin wr = 1'b1; val = XLEN'(lt_ai);           end
            CMD_SLTIU:   begin wr = 1'b1; val = XLEN'(ltu_ai);          end
            CMD_XORI:    begin wr = 1'b1; val = a ^ imm;                end
            CMD_ORI:     begin wr = 1'b1; val = a | imm;                end
            CMD_ANDI:    begin wr = 1'b1; val = a & imm;                end
            CMD_SLLI:    begin wr = 1'b1; val = a << samt_i;            end
            CMD_SRLI:    begin wr = 1'b1; val = a >> samt_i;            end
            CMD_SRAI:    begin wr = 1'b1; val = $signed(a) >>> samt_i;  end
            CMD_ADD:     begin wr = 1'b1; val = a_b_sum;                end
            CMD_SUB:     begin wr = 1'b1; val = a_b_diff;               end
            CMD_SLL:     begin wr = 1'b1; val = a << samt_r;            end
            CMD_SLT:     begin wr = 1'b1; val = XLEN'(lt_ab);           end
            CMD_SLTU:    begin wr = 1'b1; val = XLEN'(ltu_ab);          end
            CMD_XOR:     begin wr = 1'b1; val = a ^ b;                  end
            CMD_SRL:     begin wr = 1'b1; val = a >> samt_r;            end
            CMD_SRA:     begin wr = 1'b1; val = $signed(a) >>> samt_r;  end
            CMD_OR:      begin wr = 1'b1; val = a | b;                  end
            CMD_AND:     begin wr = 1'b1; val = a & b;                  end
            CMD_FENCE:   flush = 1'b0;
            CMD_FENCE_I: flush = 1'b1;
            CMD_ECALL:   begin exc = EXC_ECALL; npc = pc; end
            CMD_EBREAK:  begin exc = EXC_BREAK; npc = pc; end
            default:     flush = 1'b0;
        endcase

        // Access size and load sign follow the width of the access.
        unique case (item.command) inside
            CMD_LH, CMD_LHU, CMD_SH: size = SIZE_HALF;
            CMD_LW, CMD_SW:          size = SIZE_WORD;
            default:                 size = SIZE_BYTE;
        endcase
        unique case (item.command) inside
            CMD_LB, CMD_LH, CMD_LW: lsig = 1'b1;
            default:                lsig = 1'b0;
        endcase

        // A taken jump or branch must land on an allowed boundary; otherwise
        // it traps without touching the link register.
        misaligned = target[0] | (!compressed_enabled & target[1]);
        if (jump)
        begin
            if (misaligned)
            begin
                exc = EXC_MISALIGNED;
                npc = pc;
                wr  = 1'b0;
            end
            else
            begin
                npc = target;
            end
        end

        if (item.dest_index == 5'd0)
        begin
            wr = 1'b0;
        end
        if (!wr)
        begin
            val = '0;
        end

        result.write_enable   = wr;
        result.write_index    = item.dest_index;
        result.write_value    = 64'(val);
        result.new_pc         = 64'(npc);
        result.memory_request = req;
        result.memory_address = 64'(addr);
        result.access_size    = (req == MEM_NONE) ? SIZE_BYTE : size;
        result.load_signed    = (req == MEM_LOAD) ? lsig : 1'b0;
        result.store_value    = 64'(sval);
        result.exception_code = exc;
        result.flush_fetch    = flush;
    end

endmodule

// File: rtl/rv64_integer_execute_unit.sv
// Integer execute unit: an accepted item beat becomes its result beat.
// Throughput: one item per cycle unless result_ready stalls; an input register feeds
// the execute datapath, whose single pass of logic lands in a result register.
// Reset clears both valid flags and the compressed-mode register (compressed off).
// Depends on rv64ieu_pkg and rv64ieu_alu.
module rv64_integer_execute_unit
    import rv64ieu_pkg::*;
#(
    parameter int XLEN = DEFAULT_XLEN
)
(
    input  logic    clk,
    input  logic    rst_n,

    // Configuration write channel: one register, compressed mode.
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  logic    compressed_enabled,

    // Decoded instruction channel.
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,

    // Execution result channel.
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    // Configuration register. Writes are always taken; the surrounding system must write it
    // only while no instruction is in flight, and the block itself does not enforce this.
    logic compressed_reg;
    logic compressed_next;

    // Input register stage.
    logic  stage_valid_reg;
    logic  stage_valid_next;
    item_t stage_reg;
    item_t stage_next;

    // Result register stage.
    logic    result_valid_reg;
    logic    result_valid_next;
    result_t result_reg;
    result_t result_next;

    result_t alu_result;
    logic    stage_advance;

    assign cfg_ready = 1'b1;

    // The result register can take a new beat when it is empty or is being
    // emptied in this cycle, and the input register likewise; so a new
    // instruction enters every cycle while the consumer keeps taking results.
    assign stage_advance = !result_valid_reg || result_ready;
    assign item_ready    = !stage_valid_reg || stage_advance;

    rv64ieu_alu #(
        .XLEN (XLEN)
    ) u_alu (
        .item               (stage_reg),
        .compressed_enabled (compressed_reg),
        .result             (alu_result)
    );

    always_comb
    begin
        compressed_next   = cfg_valid ? compressed_enabled : compressed_reg;

        stage_valid_next  = item_ready ? item_valid : stage_valid_reg;
        stage_next        = (item_valid && item_ready) ? item : stage_reg;

        result_valid_next = stage_advance ? stage_valid_reg : result_valid_reg;
        result_next       = (stage_advance && stage_valid_reg) ? alu_result : result_reg;
    end

    // Control state is reset; payload registers are not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compressed_reg   <= 1'b0;
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            compressed_reg   <= compressed_next;
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg  <= stage_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: rtl/rv64ieu_checker.sv
// Port-level checks for the integer execute unit, bound to the top level.
// Depends on rv64ieu_pkg.
module rv64ieu_checker
    import rv64ieu_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // A stalled result beat holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

    // With the result side empty the unit must take a new instruction.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
    else $error("item channel blocked while result side empty");

    // A register write never targets register zero and never goes with a trap.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.write_enable |->
            result.write_index != 5'd0 && result.exception_code == EXC_NONE)
    else $error("illegal register write");

    // A fetch flush carries no write, no memory request and no trap.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.flush_fetch |->
            !result.write_enable && result.memory_request == MEM_NONE
            && result.exception_code == EXC_NONE)
    else $error("fence.i beat carries other side effects");

endmodule

bind rv64_integer_execute_unit rv64ieu_checker u_checker (.*);
